[hdl/ptfg_pkg.sv]
// Package for the PRBS test frame generator: constants, the sequencer state type,
// the structs passed between modules and the small helper functions.
// No dependencies.
`timescale 1ns / 1ps

package ptfg_pkg;

  localparam int MAX_FRAME_WORDS = 64;
  localparam int MIN_FRAME_WORDS = 2;
  localparam int HEADER_BYTES    = 12;

  localparam logic [31:0] SEED_XOR      = 32'h9E37_79B9;
  localparam logic [31:0] SEED_ZERO_SUB = 32'hDEAD_BEEF;
  localparam logic [31:0] TAIL_CONST    = 32'h5447_4E21;
  localparam logic [7:0]  MAGIC0        = 8'h51;
  localparam logic [7:0]  MAGIC1        = 8'h4B;

  localparam logic [6:0] FRAME_WORDS_RESET = 7'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_EMIT
  } seq_state_t;

  // Control from the sequencer to the generator.
  typedef struct packed {
    logic        load;
    logic        step;
    logic [31:0] seed;
  } prng_ctrl_t;

  // One finished frame word handed to the output register.
  typedef struct packed {
    logic        valid;
    logic [63:0] data;
    logic [5:0]  index;
    logic        last;
  } word_push_t;

  // One xorshift32 step with shifts 13, 17 and 5.
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // Frame length as used: below two words is two, above the maximum is the maximum.
  function automatic logic [6:0] used_words(input logic [6:0] raw);
    logic [6:0] w;
    if (raw < 7'(MIN_FRAME_WORDS)) begin
      w = 7'(MIN_FRAME_WORDS);
    end else if (raw > 7'(MAX_FRAME_WORDS)) begin
      w = 7'(MAX_FRAME_WORDS);
    end else begin
      w = raw;
    end
    return w;
  endfunction

  // Header byte at offset pos (0 to 11); other offsets give zero.
  function automatic logic [7:0] header_byte(input logic [3:0] pos,
                                             input logic [31:0] seq,
                                             input logic [8:0] fill);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = MAGIC0;
      4'd1:    b = MAGIC1;
      4'd2:    b = fill[7:0];
      4'd3:    b = {7'd0, fill[8]};
      4'd4:    b = seq[7:0];
      4'd5:    b = seq[15:8];
      4'd6:    b = seq[23:16];
      4'd7:    b = seq[31:24];
      4'd8:    b = TAIL_CONST[7:0];
      4'd9:    b = TAIL_CONST[15:8];
      4'd10:   b = TAIL_CONST[23:16];
      4'd11:   b = TAIL_CONST[31:24];
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

[hdl/ptfg_prng.sv]
// Shared xorshift32 payload generator: one state register, one step per cycle while ctrl.step is set.
// Depends on ptfg_pkg.
`timescale 1ns / 1ps

module ptfg_prng (
  input  logic                  clk,
  input  ptfg_pkg::prng_ctrl_t  ctrl,
  output logic [7:0]            rand_byte
);

  logic [31:0] x;
  logic [31:0] x_step;
  logic [31:0] seed_mix;

  assign x_step    = ptfg_pkg::xorshift32(x);
  assign seed_mix  = ctrl.seed ^ ptfg_pkg::SEED_XOR;
  // The byte of a step is the low byte of the state after that step.
  assign rand_byte = x_step[7:0];

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= (seed_mix == 32'd0) ? ptfg_pkg::SEED_ZERO_SUB : seed_mix;
    end else if (ctrl.step) begin
      x <= x_step;
    end
  end

endmodule

[hdl/ptfg_seq.sv]
// Frame sequencer: walks the frame one byte per cycle while building, assembles 8-byte words
// and hands each finished word to the output register once it is free. Depends on ptfg_pkg.
`timescale 1ns / 1ps

module ptfg_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_seq,
  input  logic [15:0]           in_fill,
  input  logic [6:0]            frame_words,
  input  logic                  out_free,
  output ptfg_pkg::word_push_t  push,
  output ptfg_pkg::prng_ctrl_t  prng_ctrl,
  input  logic [7:0]            rand_byte
);

  ptfg_pkg::seq_state_t state, state_next;

  logic [8:0]  pos, pos_next;
  logic [9:0]  pay_end, pay_end_next;
  logic [6:0]  words, words_next;
  logic [31:0] seq_r, seq_r_next;
  logic [8:0]  fill_r, fill_r_next;
  logic [63:0] word, word_next;
  logic [5:0]  widx, widx_next;

  logic [6:0]  words_c;
  logic [9:0]  room_c;
  logic [8:0]  fill_c;
  logic [7:0]  cur_byte;
  logic        is_last;

  assign words_c = ptfg_pkg::used_words(frame_words);
  assign room_c  = {words_c, 3'b000} - 10'(ptfg_pkg::HEADER_BYTES);
  assign fill_c  = ({6'd0, room_c} < in_fill) ? room_c[8:0] : in_fill[8:0];
  assign is_last = ({1'b0, widx} == (words - 7'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptfg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pos     <= pos_next;
    pay_end <= pay_end_next;
    words   <= words_next;
    seq_r   <= seq_r_next;
    fill_r  <= fill_r_next;
    word    <= word_next;
    widx    <= widx_next;
  end

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    pay_end_next   = pay_end;
    words_next     = words;
    seq_r_next     = seq_r;
    fill_r_next    = fill_r;
    word_next      = word;
    widx_next      = widx;
    in_ready       = 1'b0;
    prng_ctrl.load = 1'b0;
    prng_ctrl.step = 1'b0;
    prng_ctrl.seed = in_seq;
    push.valid     = 1'b0;
    push.data      = word;
    push.index     = widx;
    push.last      = is_last;
    cur_byte       = 8'd0;

    unique case (state)
      ptfg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          prng_ctrl.load = 1'b1;
          pos_next       = 9'd0;
          widx_next      = 6'd0;
          words_next     = words_c;
          seq_r_next     = in_seq;
          fill_r_next    = fill_c;
          pay_end_next   = {1'b0, fill_c} + 10'(ptfg_pkg::HEADER_BYTES);
          state_next     = ptfg_pkg::ST_BUILD;
        end
      end
      ptfg_pkg::ST_BUILD: begin
        if (pos < 9'(ptfg_pkg::HEADER_BYTES)) begin
          cur_byte = ptfg_pkg::header_byte(pos[3:0], seq_r, fill_r);
        end else if ({1'b0, pos} < pay_end) begin
          cur_byte       = rand_byte;
          prng_ctrl.step = 1'b1;
        end
        word_next = {cur_byte, word[63:8]};
        pos_next  = pos + 9'd1;
        if (pos[2:0] == 3'd7) begin
          state_next = ptfg_pkg::ST_EMIT;
        end
      end
      ptfg_pkg::ST_EMIT: begin
        if (out_free) begin
          push.valid = 1'b1;
          widx_next  = widx + 6'd1;
          state_next = is_last ? ptfg_pkg::ST_IDLE : ptfg_pkg::ST_BUILD;
        end
      end
      default: begin
        state_next = ptfg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/prbs_test_frame_generator.sv]
// Top level of the PRBS test frame generator: configuration register, output
// register and the sequencer with its shared payload generator.
// Depends on ptfg_pkg, ptfg_prng and ptfg_seq.
`timescale 1ns / 1ps

// Usage
// A request transaction on the s_ channel carries a sequence number and a payload
// fill length. The block answers with one test frame on the m_ channel: the clamped
// frame_words transactions of eight bytes each, the byte at the lowest offset in bits
// 7..0, the final word marked by m_tlast. The frame starts with a 12-byte header,
// then the clamped number of xorshift32 payload bytes, then zero padding.
// The frame length register is written through cfg_valid/cfg_data, which is always
// ready; writes are meant for idle periods and take effect on the next request.
// Timing: the sequencer builds one byte per cycle in its build state, then hands each
// finished word to the output register in its emit state, which waits while the
// register is full; m_tvalid is registered and rises once the first word is handed over.
// The byte-at-a-time walk through the single xorshift32 step unit sets this pace.
// s_tready is high only while no frame is being built. A new request may be taken
// while the final word still waits in the output register.
// When the receiver stalls, the finished word waits in the output register and the
// sequencer holds the next word until the register frees up; nothing is dropped.
// Reset (rst, synchronous) returns the frame length to 16 words, empties the output
// register and returns the sequencer to idle.

module prbs_test_frame_generator (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [31:0] seq, [47:32] fill
  // Frame word channel.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] frame_word, [69:64] word_index, [71:70] zero
  output logic        m_tlast,   // last
  // Frame length register.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data   // frame_words
);

  logic [6:0]  frame_words;
  logic        out_free;
  logic [63:0] out_word;
  logic [5:0]  out_index;

  ptfg_pkg::word_push_t push;
  ptfg_pkg::prng_ctrl_t prng_ctrl;
  logic [7:0]           rand_byte;

  assign cfg_ready = 1'b1;

  // The register keeps the raw bits; the sequencer clamps them per frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_words <= ptfg_pkg::FRAME_WORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_words <= cfg_data;
    end
  end

  // Output register: free when empty or being drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && push.valid) begin
      out_word  <= push.data;
      out_index <= push.index;
      m_tlast   <= push.last;
    end
  end

  assign m_tdata = {2'b00, out_index, out_word};

  ptfg_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_seq      (s_tdata[31:0]),
    .in_fill     (s_tdata[47:32]),
    .frame_words (frame_words),
    .out_free    (out_free),
    .push        (push),
    .prng_ctrl   (prng_ctrl),
    .rand_byte   (rand_byte)
  );

  ptfg_prng u_prng (
    .clk       (clk),
    .ctrl      (prng_ctrl),
    .rand_byte (rand_byte)
  );

  // A new request is never taken in the cycle right after one was taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while a frame was in progress");

  // The sequencer only hands over a word when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && m_tvalid && !m_tready))
    else $error("word pushed into a full output register");

  // Every first word of a frame starts with the two magic bytes.
  a_magic: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_index == 6'd0) |->
      (out_word[7:0] == ptfg_pkg::MAGIC0) && (out_word[15:8] == ptfg_pkg::MAGIC1))
    else $error("first frame word lacks the magic bytes");

  // While idle, the output register is empty or holds the final word of a frame.
  a_idle_tail: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tlast)
    else $error("sequencer idle in the middle of a frame");

endmodule
